// ----- design/rtt_pkg.sv -----
// Shared types and constants for the repeating timer table.
// Used by the front decoder, the job queue, the scan engine and the top level.
// No dependencies.
package rtt_pkg;

   // table size default, handed down from the top level
   localparam int TIMER_SLOTS_DEF = 16;

   // field widths
   localparam int OP_W     = 2;
   localparam int TIME_W   = 64;
   localparam int WORD_W   = 32;
   localparam int KIND_W   = 3;
   localparam int FIRED_W  = 5;

   // milliseconds to microseconds, and the width of period times that factor
   localparam int MS_TO_US = 1000;
   localparam int STEP_W   = 42;

   // repeat count that never runs out
   localparam logic [WORD_W-1:0] REPEAT_FOREVER = '1;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // request op codes
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // classified command carried to the back end
   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_ADD,
      CMD_DELETE
   } cmd_type;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ADDED   = 3'd0,
      KIND_FULL    = 3'd1,
      KIND_DELETED = 3'd2,
      KIND_FIRED   = 3'd3,
      KIND_DONE    = 3'd4
   } kind_type;

   // one queued job
   typedef struct packed {
      cmd_type             cmd;
      logic [TIME_W-1:0]   now_us;
      logic [WORD_W-1:0]   period_ms;
      logic [WORD_W-1:0]   repeat_count;
      logic [WORD_W-1:0]   timer_ident;
   } job_type;

endpackage

// ----- design/rtt_front.sv -----
// Front end of the timer table: takes request beats and classifies them.
// Depends on rtt_pkg; feeds rtt_queue with job_type beats.
module rtt_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rtt_pkg::OP_W-1:0]   req_op,
   input  logic [rtt_pkg::TIME_W-1:0] req_now_us,
   input  logic [rtt_pkg::WORD_W-1:0] req_period_ms,
   input  logic [rtt_pkg::WORD_W-1:0] req_repeat_count,
   input  logic [rtt_pkg::WORD_W-1:0] req_timer_ident,
   output logic                       job_valid,
   input  logic                       job_ready,
   output rtt_pkg::job_type           job
);
   import rtt_pkg::*;

   logic known;

   // decode the op; the unused code is swallowed without a job
   always_comb begin
      known   = 1'b1;
      job.cmd = CMD_TICK;
      unique case (req_op)
         OP_TICK:   job.cmd = CMD_TICK;
         OP_ADD:    job.cmd = CMD_ADD;
         OP_DELETE: job.cmd = CMD_DELETE;
         default:   known = 1'b0;
      endcase
      job.now_us       = req_now_us;
      job.period_ms    = req_period_ms;
      job.repeat_count = req_repeat_count;
      job.timer_ident  = req_timer_ident;
   end

   // pass known beats to the queue, drop the rest at once
   assign job_valid = req_valid && known;
   assign req_ready = known ? job_ready : 1'b1;

endmodule

// ----- design/rtt_queue.sv -----
// Short job queue that decouples the front end from the scan engine.
// Depends on rtt_pkg for job_type and QUEUE_DEPTH.
module rtt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  rtt_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output rtt_pkg::job_type pop_job
);
   import rtt_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold the entries; no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- design/rtt_back.sv -----
// Back end of the timer table: slot memory, per-slot flags and the scan engine.
// Depends on rtt_pkg; takes job_type beats from rtt_queue, drives result beats.
module rtt_back #(
   parameter int TIMER_SLOTS = rtt_pkg::TIMER_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   output logic                        job_ready,
   input  rtt_pkg::job_type            job,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rtt_pkg::KIND_W-1:0]  rsp_kind,
   output logic [rtt_pkg::WORD_W-1:0]  rsp_timer_ident_res,
   output logic [rtt_pkg::FIRED_W-1:0] rsp_fired_count,
   output logic [rtt_pkg::WORD_W-1:0]  rsp_min_period_ms,
   output logic                        rsp_last
);
   import rtt_pkg::*;

   localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);

   typedef struct packed {
      logic [WORD_W-1:0] ident;
      logic [STEP_W-1:0] step;
      logic [WORD_W-1:0] repeats;
      logic [TIME_W-1:0] deadline;
   } row_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_ADD_WR,
      ST_FINISH
   } state_type;

   // slot memory
   row_type             mem [TIMER_SLOTS];
   row_type             rd_row_ff;
   logic                rd_en, wr_en;
   logic [SLOT_W-1:0]   rd_addr, wr_addr;
   row_type             wr_row;

   // control state
   state_type           state_ff, state_in;
   job_type             job_ff, job_in;
   logic [CNT_W-1:0]    rd_cnt_ff, rd_cnt_in;
   logic                eval_vld_ff, eval_vld_in;
   logic [SLOT_W-1:0]   eval_idx_ff, eval_idx_in;
   logic                found_ff, found_in;
   logic [SLOT_W-1:0]   found_idx_ff, found_idx_in;
   logic [FIRED_W-1:0]  fired_ff, fired_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [WORD_W-1:0]   ident_ctr_ff, ident_ctr_in;
   logic [WORD_W-1:0]   min_period_ff, min_period_in;
   logic [TIMER_SLOTS-1:0] used_ff, used_in;
   logic [TIMER_SLOTS-1:0] active_ff, active_in;
   logic [TIMER_SLOTS-1:0] doomed_ff, doomed_in;

   // result register
   logic                rsp_vld_ff, rsp_vld_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic [WORD_W-1:0]   rsp_ident_ff, rsp_ident_in;
   logic [FIRED_W-1:0]  rsp_fired_ff, rsp_fired_in;
   logic [WORD_W-1:0]   rsp_minp_ff, rsp_minp_in;
   logic                rsp_last_ff, rsp_last_in;

   // scan helpers
   logic                out_free;
   logic                cur_used, cur_active, cur_doomed;
   logic                tick_free, tick_fire;
   logic                need_emit, eval_go, advance, issue, scan_end;
   logic [TIME_W-1:0]   fire_deadline, add_deadline;
   logic [WORD_W-1:0]   ident_next, minp_next;

   assign out_free   = !rsp_vld_ff || rsp_ready;
   assign cur_used   = used_ff[eval_idx_ff];
   assign cur_active = active_ff[eval_idx_ff];
   assign cur_doomed = doomed_ff[eval_idx_ff];

   // classify the slot under evaluation for a tick
   assign tick_free = cur_used && (cur_doomed
                      || (cur_active && (rd_row_ff.repeats == '0)));
   assign tick_fire = cur_used && !cur_doomed && cur_active
                      && (rd_row_ff.repeats != '0)
                      && (rd_row_ff.deadline < job_ff.now_us);

   assign need_emit = (job_ff.cmd == CMD_TICK) && tick_fire;
   assign eval_go   = eval_vld_ff && (!need_emit || out_free);
   assign advance   = !eval_vld_ff || eval_go;
   assign issue     = advance && (rd_cnt_ff != CNT_W'(TIMER_SLOTS));
   assign scan_end  = !eval_vld_ff && (rd_cnt_ff == CNT_W'(TIMER_SLOTS));

   assign fire_deadline = rd_row_ff.deadline + TIME_W'(rd_row_ff.step);
   assign add_deadline  = job_ff.now_us + TIME_W'(step_ff);
   assign ident_next    = ident_ctr_ff + 1'b1;
   assign minp_next     = (job_ff.period_ms < min_period_ff) ? job_ff.period_ms
                                                              : min_period_ff;

   // sequencer: scan slots one a cycle while no fired beat waits on the result, then finish the job
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      rd_cnt_in     = rd_cnt_ff;
      eval_vld_in   = eval_vld_ff;
      eval_idx_in   = eval_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      fired_in      = fired_ff;
      step_in       = step_ff;
      ident_ctr_in  = ident_ctr_ff;
      min_period_in = min_period_ff;
      used_in       = used_ff;
      active_in     = active_ff;
      doomed_in     = doomed_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_ident_in  = rsp_ident_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_minp_in   = rsp_minp_ff;
      rsp_last_in   = rsp_last_ff;
      job_ready     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = rd_cnt_ff[SLOT_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = eval_idx_ff;
      wr_row        = rd_row_ff;

      unique case (state_ff)
         ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               job_in      = job;
               found_in    = 1'b0;
               fired_in    = '0;
               rd_cnt_in   = '0;
               eval_vld_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // act on the slot whose row has just been read
            if (eval_go) begin
               unique case (job_ff.cmd)
                  CMD_TICK: begin
                     if (tick_free) begin
                        used_in[eval_idx_ff]   = 1'b0;
                        active_in[eval_idx_ff] = 1'b0;
                        doomed_in[eval_idx_ff] = 1'b0;
                     end else if (tick_fire) begin
                        wr_en           = 1'b1;
                        wr_row.deadline = fire_deadline;
                        if (rd_row_ff.repeats != REPEAT_FOREVER) begin
                           wr_row.repeats = rd_row_ff.repeats - 1'b1;
                        end
                        fired_in     = fired_ff + 1'b1;
                        rsp_vld_in   = 1'b1;
                        rsp_kind_in  = KIND_FIRED;
                        rsp_ident_in = rd_row_ff.ident;
                        rsp_fired_in = '0;
                        rsp_minp_in  = min_period_ff;
                        rsp_last_in  = 1'b0;
                     end
                  end
                  CMD_ADD: begin
                     if (!cur_used && !found_ff) begin
                        found_in     = 1'b1;
                        found_idx_in = eval_idx_ff;
                     end
                  end
                  CMD_DELETE: begin
                     if (cur_used && !found_ff
                         && (rd_row_ff.ident == job_ff.timer_ident)) begin
                        found_in               = 1'b1;
                        active_in[eval_idx_ff] = 1'b0;
                        doomed_in[eval_idx_ff] = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            // issue the next read
            if (advance) begin
               eval_vld_in = issue;
               eval_idx_in = rd_addr;
               if (issue) begin
                  rd_en     = 1'b1;
                  rd_cnt_in = rd_cnt_ff + 1'b1;
               end
            end
            if (scan_end) begin
               state_in = (job_ff.cmd == CMD_ADD && found_ff) ? ST_MUL : ST_FINISH;
            end
         end

         ST_MUL: begin
            step_in  = STEP_W'(job_ff.period_ms) * STEP_W'(MS_TO_US);
            state_in = ST_ADD_WR;
         end

         ST_ADD_WR: begin
            // install the new timer and report it
            if (out_free) begin
               wr_en                   = 1'b1;
               wr_addr                 = found_idx_ff;
               wr_row.ident            = ident_next;
               wr_row.step             = step_ff;
               wr_row.repeats          = job_ff.repeat_count;
               wr_row.deadline         = add_deadline;
               used_in[found_idx_ff]   = 1'b1;
               active_in[found_idx_ff] = 1'b1;
               doomed_in[found_idx_ff] = 1'b0;
               ident_ctr_in            = ident_next;
               min_period_in           = minp_next;
               rsp_vld_in              = 1'b1;
               rsp_kind_in             = KIND_ADDED;
               rsp_ident_in            = ident_next;
               rsp_fired_in            = '0;
               rsp_minp_in             = minp_next;
               rsp_last_in             = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         ST_FINISH: begin
            // closing beat of a tick, a delete or a refused add
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_fired_in = '0;
               rsp_ident_in = '0;
               rsp_minp_in  = min_period_ff;
               rsp_last_in  = 1'b1;
               unique case (job_ff.cmd)
                  CMD_TICK: begin
                     rsp_kind_in  = KIND_DONE;
                     rsp_fired_in = fired_ff;
                  end
                  CMD_DELETE: begin
                     rsp_kind_in  = KIND_DELETED;
                     rsp_ident_in = job_ff.timer_ident;
                  end
                  default: rsp_kind_in = KIND_FULL;
               endcase
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         eval_vld_ff   <= 1'b0;
         rd_cnt_ff     <= '0;
         found_ff      <= 1'b0;
         fired_ff      <= '0;
         ident_ctr_ff  <= '0;
         min_period_ff <= '1;
         used_ff       <= '0;
         active_ff     <= '0;
         doomed_ff     <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         eval_vld_ff   <= eval_vld_in;
         rd_cnt_ff     <= rd_cnt_in;
         found_ff      <= found_in;
         fired_ff      <= fired_in;
         ident_ctr_ff  <= ident_ctr_in;
         min_period_ff <= min_period_in;
         used_ff       <= used_in;
         active_ff     <= active_in;
         doomed_ff     <= doomed_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      job_ff       <= job_in;
      eval_idx_ff  <= eval_idx_in;
      found_idx_ff <= found_idx_in;
      step_ff      <= step_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_ident_ff <= rsp_ident_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_minp_ff  <= rsp_minp_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // slot memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_timer_ident_res = rsp_ident_ff;
   assign rsp_fired_count     = rsp_fired_ff;
   assign rsp_min_period_ms   = rsp_minp_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ----- design/repeating_timer_table_top.sv -----
// Top level of the repeating timer table: front decoder, job queue, scan engine.
// Depends on rtt_pkg, rtt_front, rtt_queue and rtt_back.
//
//   Channel | Ports  | Beat
//   --------+--------+-------------------------------------------------------
//   request | req_*  | op, now_us, period_ms, repeat_count, timer_ident
//   result  | rsp_*  | kind, timer_ident_res, fired_count, min_period_ms, last
//
// Every job walks the slot memory one slot a cycle through its single read
// port, but a tick's walk stalls while a fired beat waits on rsp_ready; a tick
// or a delete then shows its last beat from the finish state, and the engine
// is then free for the next job. An add that finds a free slot first multiplies
// its period, then installs the timer; a refused add closes like a delete.
// Reset clears the slot flags and the id counter and sets the smallest period to all ones.
// The queue keeps taking requests while the engine is busy or the result stalls, until it holds QUEUE_DEPTH jobs.
module repeating_timer_table_top #(
   parameter int TIMER_SLOTS = rtt_pkg::TIMER_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rtt_pkg::OP_W-1:0]    req_op,
   input  logic [rtt_pkg::TIME_W-1:0]  req_now_us,
   input  logic [rtt_pkg::WORD_W-1:0]  req_period_ms,
   input  logic [rtt_pkg::WORD_W-1:0]  req_repeat_count,
   input  logic [rtt_pkg::WORD_W-1:0]  req_timer_ident,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rtt_pkg::KIND_W-1:0]  rsp_kind,
   output logic [rtt_pkg::WORD_W-1:0]  rsp_timer_ident_res,
   output logic [rtt_pkg::FIRED_W-1:0] rsp_fired_count,
   output logic [rtt_pkg::WORD_W-1:0]  rsp_min_period_ms,
   output logic                        rsp_last
);
   import rtt_pkg::*;

   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop_ready;
   job_type pop_job;

   // classify requests
   rtt_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_now_us       (req_now_us),
      .req_period_ms    (req_period_ms),
      .req_repeat_count (req_repeat_count),
      .req_timer_ident  (req_timer_ident),
      .job_valid        (push_valid),
      .job_ready        (push_ready),
      .job              (push_job)
   );

   // decouple front from back
   rtt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // run jobs against the slot table
   rtt_back #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .job_valid           (pop_valid),
      .job_ready           (pop_ready),
      .job                 (pop_job),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_timer_ident_res (rsp_timer_ident_res),
      .rsp_fired_count     (rsp_fired_count),
      .rsp_min_period_ms   (rsp_min_period_ms),
      .rsp_last            (rsp_last)
   );

endmodule

// ----- test/tb_repeating_timer_table_top.sv -----
// Testbench for the repeating timer table: directed and random add, delete and tick
// requests, with every result beat checked in order against a shadow of the slot table.
// Depends on rtt_pkg and repeating_timer_table_top.
module tb_repeating_timer_table_top;
   import rtt_pkg::*;

   localparam int NSLOT        = TIMER_SLOTS_DEF;
   localparam int RAND_ITEMS   = 380;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] now_us;
      logic [WORD_W-1:0] period_ms;
      logic [WORD_W-1:0] repeat_count;
      logic [WORD_W-1:0] timer_ident;
   } timer_req_type;

   typedef struct {
      kind_type           kind;
      logic [WORD_W-1:0]  ident;
      logic [FIRED_W-1:0] fired;
      logic [WORD_W-1:0]  min_period;
      logic               last;
   } timer_rsp_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_ALTERNATE,
      RDY_RANDOM,
      RDY_STALLS
   } ready_mode_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_op           = '0;
   logic [TIME_W-1:0]   req_now_us       = '0;
   logic [WORD_W-1:0]   req_period_ms    = '0;
   logic [WORD_W-1:0]   req_repeat_count = '0;
   logic [WORD_W-1:0]   req_timer_ident  = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [WORD_W-1:0]   rsp_timer_ident_res;
   logic [FIRED_W-1:0]  rsp_fired_count;
   logic [WORD_W-1:0]   rsp_min_period_ms;
   logic                rsp_last;

   // shadow of the slot table
   bit                  tbl_used     [NSLOT];
   bit                  tbl_active   [NSLOT];
   bit                  tbl_doomed   [NSLOT];
   logic [WORD_W-1:0]   tbl_ident    [NSLOT];
   logic [WORD_W-1:0]   tbl_period   [NSLOT];
   logic [WORD_W-1:0]   tbl_repeats  [NSLOT];
   logic [TIME_W-1:0]   tbl_deadline [NSLOT];
   logic [WORD_W-1:0]   ident_count  = '0;
   logic [WORD_W-1:0]   least_period = '1;

   timer_req_type       stim_q[$];
   timer_rsp_type       expected_rsp_q[$];

   int                  issued        = 0;
   int                  accepted      = 0;
   int                  work_items    = 0;
   int                  beats_checked = 0;
   int                  fired_seen    = 0;
   int                  full_seen     = 0;
   int                  fail_count    = 0;
   int                  cycle_count   = 0;

   repeating_timer_table_top #(
      .TIMER_SLOTS(NSLOT)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_now_us          (req_now_us),
      .req_period_ms       (req_period_ms),
      .req_repeat_count    (req_repeat_count),
      .req_timer_ident     (req_timer_ident),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_timer_ident_res (rsp_timer_ident_res),
      .rsp_fired_count     (rsp_fired_count),
      .rsp_min_period_ms   (rsp_min_period_ms),
      .rsp_last            (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [TIME_W-1:0] ms_to_us(input logic [WORD_W-1:0] ms);
      return {{(TIME_W-WORD_W){1'b0}}, ms} * 64'(MS_TO_US);
   endfunction

   function automatic logic [TIME_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic timer_rsp_type make_rsp(input kind_type k, input logic [WORD_W-1:0] id,
                                              input logic [FIRED_W-1:0] f, input logic l);
      timer_rsp_type r;
      r.kind       = k;
      r.ident      = id;
      r.fired      = f;
      r.min_period = least_period;
      r.last       = l;
      return r;
   endfunction

   // Advance the shadow table by one accepted request and queue the beats it owes
   task automatic apply_timer_op(input timer_req_type rq);
      int                 i;
      int                 slot;
      int                 fired;
      logic [FIRED_W-1:0] fired_bits;
      case (rq.op)
         OP_ADD: begin
            slot = -1;
            for (i = 0; i < NSLOT; i++)
               if (slot < 0 && !tbl_used[i]) slot = i;
            if (slot < 0) begin
               full_seen++;
               expected_rsp_q.push_back(make_rsp(KIND_FULL, '0, '0, 1'b1));
            end else begin
               ident_count          = ident_count + 1'b1;
               tbl_used[slot]       = 1'b1;
               tbl_active[slot]     = 1'b1;
               tbl_doomed[slot]     = 1'b0;
               tbl_ident[slot]      = ident_count;
               tbl_period[slot]     = rq.period_ms;
               tbl_repeats[slot]    = rq.repeat_count;
               tbl_deadline[slot]   = rq.now_us + ms_to_us(rq.period_ms);
               if (rq.period_ms < least_period) least_period = rq.period_ms;
               expected_rsp_q.push_back(make_rsp(KIND_ADDED, ident_count, '0, 1'b1));
            end
         end
         OP_DELETE: begin
            slot = -1;
            for (i = 0; i < NSLOT; i++)
               if (slot < 0 && tbl_used[i] && tbl_ident[i] == rq.timer_ident) slot = i;
            if (slot >= 0) begin
               tbl_active[slot] = 1'b0;
               tbl_doomed[slot] = 1'b1;
            end
            expected_rsp_q.push_back(make_rsp(KIND_DELETED, rq.timer_ident, '0, 1'b1));
         end
         OP_TICK: begin
            fired = 0;
            for (i = 0; i < NSLOT; i++) begin
               if (!tbl_used[i]) begin
               end else if (tbl_doomed[i] || (tbl_active[i] && tbl_repeats[i] == '0)) begin
                  // free doomed and spent timers
                  tbl_used[i]   = 1'b0;
                  tbl_active[i] = 1'b0;
                  tbl_doomed[i] = 1'b0;
               end else if (tbl_active[i] && tbl_deadline[i] < rq.now_us) begin
                  fired++;
                  expected_rsp_q.push_back(make_rsp(KIND_FIRED, tbl_ident[i], '0, 1'b0));
                  tbl_deadline[i] = tbl_deadline[i] + ms_to_us(tbl_period[i]);
                  if (tbl_repeats[i] != REPEAT_FOREVER) tbl_repeats[i] = tbl_repeats[i] - 1'b1;
               end
            end
            fired_seen += fired;
            fired_bits = FIRED_W'(fired);
            expected_rsp_q.push_back(make_rsp(KIND_DONE, '0, fired_bits, 1'b1));
         end
         default: begin
            // unused op: no beat, no change
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic push_req(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                           input logic [WORD_W-1:0] per, input logic [WORD_W-1:0] rep,
                           input logic [WORD_W-1:0] id);
      timer_req_type rq;
      rq.op           = op;
      rq.now_us       = now;
      rq.period_ms    = per;
      rq.repeat_count = rep;
      rq.timer_ident  = id;
      stim_q.push_back(rq);
      if (op != OP_UNUSED) work_items++;
   endtask

   // Request driver: bursts of beats with random gaps, hold until taken
   int gap_left   = 0;
   int burst_left = 1;

   always @(negedge clock) begin
      timer_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || accepted == issued) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (stim_q.size() != 0) begin
            nxt = stim_q.pop_front();
            req_op           <= nxt.op;
            req_now_us       <= nxt.now_us;
            req_period_ms    <= nxt.period_ms;
            req_repeat_count <= nxt.repeat_count;
            req_timer_ident  <= nxt.timer_ident;
            req_valid        <= 1'b1;
            issued++;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure: switch to a randomly chosen pattern whenever the current one runs out
   ready_mode_type rdy_mode   = RDY_ALWAYS;
   int             mode_left  = 0;
   int             stall_left = 0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         rdy_mode  = ready_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(16, 96);
      end else begin
         mode_left--;
      end
      case (rdy_mode)
         RDY_ALWAYS:    rsp_ready <= 1'b1;
         RDY_ALTERNATE: rsp_ready <= ~rsp_ready;
         RDY_RANDOM:    rsp_ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 16);
            end
         end
      endcase
   end

   // Monitor: predict on each request beat, check each result beat
   always @(posedge clock) begin
      timer_req_type rq;
      timer_rsp_type exp_rsp;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("repeating_timer_table_top test failed");
         $finish;
      end else if (!reset) begin
         if (req_valid && req_ready) begin
            rq.op           = req_op;
            rq.now_us       = req_now_us;
            rq.period_ms    = req_period_ms;
            rq.repeat_count = req_repeat_count;
            rq.timer_ident  = req_timer_ident;
            apply_timer_op(rq);
            accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("result beat with nothing outstanding: kind %0d ident 0x%0h",
                      rsp_kind, rsp_timer_ident_res);
               fail_count++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               check_field("kind", TIME_W'(exp_rsp.kind), TIME_W'(rsp_kind));
               check_field("timer_ident_res", TIME_W'(exp_rsp.ident),
                           TIME_W'(rsp_timer_ident_res));
               check_field("fired_count", TIME_W'(exp_rsp.fired), TIME_W'(rsp_fired_count));
               check_field("min_period_ms", TIME_W'(exp_rsp.min_period),
                           TIME_W'(rsp_min_period_ms));
               check_field("last", TIME_W'(exp_rsp.last), TIME_W'(rsp_last));
               beats_checked++;
            end
         end
      end
   end

   initial begin
      int                k;
      int                n;
      int                r;
      bit                noisy;
      logic [TIME_W-1:0] gen_now;
      logic [TIME_W-1:0] t;
      logic [WORD_W-1:0] per;
      logic [WORD_W-1:0] rep;
      logic [WORD_W-1:0] id;
      logic [WORD_W-1:0] live_ids[$];
      logic [TIME_W-1:0] live_deadlines[$];

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, ignored op, unknown id, zero repeats, forever,
      // strict deadline, delete then free, deadline wrap, table full
      push_req(OP_TICK, '0, '0, '0, '0);
      push_req(OP_UNUSED, '1, '1, '1, '1);
      push_req(OP_DELETE, '0, '0, '0, 32'd7);
      push_req(OP_ADD, '0, '1, REPEAT_FOREVER, '0);
      push_req(OP_ADD, '0, 32'd2, '0, '0);
      push_req(OP_ADD, '0, 32'd1, 32'd2, '0);
      push_req(OP_ADD, '0, 32'd1, REPEAT_FOREVER, '0);
      push_req(OP_TICK, 64'd1000, '0, '0, '0);
      push_req(OP_TICK, 64'd1001, '0, '0, '0);
      push_req(OP_DELETE, '0, '0, '0, 32'd4);
      push_req(OP_TICK, 64'd5000, '0, '0, '0);
      for (k = 0; k < NSLOT - 2; k++) begin
         if (k == 0) push_req(OP_ADD, '1 - 64'd499, 32'd1, 32'd2, '0);
         else push_req(OP_ADD, 64'd6000, $urandom_range(1, 9), $urandom_range(1, 3), '0);
      end
      push_req(OP_ADD, 64'd6000, 32'd5, 32'd1, '0);
      push_req(OP_TICK, 64'd20000, '0, '0, '0);

      // Random: episodes built from the live table, mostly well-formed traffic
      work_items = 0;
      gen_now    = 64'd20000;
      while (work_items < RAND_ITEMS) begin
         while (stim_q.size() != 0 || accepted != issued) @(negedge clock);
         @(posedge clock);
         live_ids.delete();
         live_deadlines.delete();
         for (k = 0; k < NSLOT; k++) begin
            if (tbl_used[k]) live_ids.push_back(tbl_ident[k]);
            if (tbl_used[k] && tbl_active[k]) live_deadlines.push_back(tbl_deadline[k]);
         end
         noisy = ($urandom_range(0, 99) < 15);
         n     = $urandom_range(8, 24);
         for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (noisy) begin
               push_req(OP_W'($urandom_range(0, 3)), rand64(), $urandom, $urandom, $urandom);
            end else if (r < ((live_ids.size() >= NSLOT - 2) ? 25 : 40)) begin
               // add: mostly short periods and few repeats
               r = $urandom_range(0, 99);
               if (r < 85) per = $urandom_range(1, 40);
               else if (r < 95) per = $urandom_range(41, 100000);
               else per = $urandom;
               if (work_items > RAND_ITEMS - 40 && $urandom_range(0, 9) == 0) per = '0;
               r = $urandom_range(0, 99);
               if (r < 40) rep = $urandom_range(1, 3);
               else if (r < 60) rep = '0;
               else if (r < 80) rep = REPEAT_FOREVER;
               else if (r < 90) rep = $urandom_range(4, 20);
               else rep = $urandom;
               push_req(OP_ADD, gen_now, per, rep, $urandom);
            end else if (r < 65) begin
               // delete: live id, a soon-to-be id, or anything
               r = $urandom_range(0, 99);
               if (r < 70 && live_ids.size() != 0)
                  id = live_ids[$urandom_range(0, live_ids.size() - 1)];
               else if (r < 90) id = ident_count + 1'b1 + $urandom_range(0, 2);
               else id = $urandom;
               push_req(OP_DELETE, rand64(), $urandom, $urandom, id);
            end else begin
               // tick: land on a deadline, repeat the time, or move on
               r = $urandom_range(0, 99);
               if (r < 30 && live_deadlines.size() != 0) begin
                  t = live_deadlines[$urandom_range(0, live_deadlines.size() - 1)]
                      + $urandom_range(0, 1);
               end else if (r < 45) begin
                  t = gen_now;
               end else begin
                  gen_now = gen_now + $urandom_range(1, 12000);
                  t       = gen_now;
               end
               push_req(OP_TICK, t, $urandom, $urandom, $urandom);
            end
         end
      end

      // Drain: all requests taken, all beats seen, then a short quiet spell
      while (stim_q.size() != 0 || accepted != issued) @(negedge clock);
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d requests driven, %0d result beats checked,", accepted, beats_checked);
      $display("%0d timer firings, %0d full-table refusals", fired_seen, full_seen);
      if (fail_count == 0) begin
         $display("repeating_timer_table_top test passed");
      end else begin
         $display("repeating_timer_table_top test failed");
      end
      $finish;
   end

endmodule
